// ===== rtl/cda_pkg.sv =====
// Shared types, constants and helper functions for the calendar date adder.
// Used by every module under rtl; depends on nothing.
package cda_pkg;

    localparam int DEF_YEAR_BITS   = 16;
    localparam int DEF_COUNT_BITS  = 16;

    localparam int DAY_W           = 5;
    localparam int MONTH_W         = 4;
    localparam int FIELD_YEAR_W    = 16;
    localparam int FIELD_COUNT_W   = 16;
    localparam int UPC_W           = 4;

    localparam int DAYS_FOUR_YEARS = 1461;

    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_ONE  = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_LAST = 5'd31;

    typedef logic [UPC_W-1:0] upc_t;

    // Microprogram step addresses
    localparam upc_t UA_EMIT       = 4'd0;
    localparam upc_t UA_WAIT       = 4'd1;
    localparam upc_t UA_DISPATCH   = 4'd2;
    localparam upc_t UA_CHECK      = 4'd3;
    localparam upc_t UA_QUAD_TEST  = 4'd4;
    localparam upc_t UA_QUAD       = 4'd5;
    localparam upc_t UA_FIT_TEST   = 4'd6;
    localparam upc_t UA_YEAR_TEST  = 4'd7;
    localparam upc_t UA_NEXT_MONTH = 4'd8;
    localparam upc_t UA_ADD_DAY    = 4'd9;
    localparam upc_t UA_LOAD       = 4'd10;
    localparam upc_t UA_SATURATE   = 4'd11;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_ADD  = 1'b1
    } operation_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_ST_BAD,
        DP_ST_OK,
        DP_QUAD,
        DP_NEXT_MONTH,
        DP_ADD_DAY,
        DP_LOAD,
        DP_SATURATE
    } dp_op_t;

    typedef enum logic [2:0] {
        CD_ALWAYS,
        CD_NO_INPUT,
        CD_OP_LOAD,
        CD_INVALID,
        CD_NOT_QUAD,
        CD_FITS,
        CD_YEAR_END,
        CD_OUT_BUSY
    } cond_t;

    typedef struct packed {
        dp_op_t dp_op;
        cond_t  cond;
        upc_t   target;
        logic   accept;
        logic   emit;
    } ctrl_word_t;

    typedef struct packed {
        logic op_load;
        logic invalid;
        logic not_quad;
        logic fits;
        logic year_end;
    } dp_flags_t;

    function automatic ctrl_word_t mk_word(dp_op_t dp_op, cond_t cond, upc_t target,
                                           logic accept, logic emit);
        ctrl_word_t w;
        w.dp_op  = dp_op;
        w.cond   = cond;
        w.target = target;
        w.accept = accept;
        w.emit   = emit;
        return w;
    endfunction

    // Days in a month; zero for a month outside 1..12
    function automatic logic [DAY_W-1:0] month_len(logic [MONTH_W-1:0] month, logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            MON_FEB:                 len = leap ? 5'd29 : 5'd28;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, MON_DEC:    len = 5'd31;
            default:                 len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/calendar_date_adder.sv =====
// Top level of the calendar date adder: microcoded sequencer, datapath and
// result register. Depends on cda_pkg, cda_sequencer and cda_datapath.
//
//  channel  ports                                            direction
//  input    s_valid s_ready s_operation s_load_day            in
//           s_load_month s_load_year s_day_count
//  result   m_valid m_ready m_cur_day m_cur_month             out
//           m_cur_year m_status
//
// A load passes the wait, dispatch, load and emit steps. An add walks the
// date on the one month-step datapath stepped by the microprogram: whole
// four-year blocks first, then single months, then the remaining days.
// Reset (aresetn low, synchronous) clears the stored date to zero. The next
// item is accepted while a result waits in the output register; a stalled
// result holds the program at its emit step.
module calendar_date_adder
    import cda_pkg::*;
#(
    parameter int YEAR_BITS  = DEF_YEAR_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_operation,
    input  logic [DAY_W-1:0]         s_load_day,
    input  logic [MONTH_W-1:0]       s_load_month,
    input  logic [FIELD_YEAR_W-1:0]  s_load_year,
    input  logic [FIELD_COUNT_W-1:0] s_day_count,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [DAY_W-1:0]         m_cur_day,
    output logic [MONTH_W-1:0]       m_cur_month,
    output logic [FIELD_YEAR_W-1:0]  m_cur_year,
    output logic [1:0]               m_status
);

    ctrl_word_t              ctrl;
    dp_flags_t               flags;
    logic                    capture;
    logic                    out_busy;
    logic                    emit_fire;
    logic [DAY_W-1:0]        cur_day;
    logic [MONTH_W-1:0]      cur_month;
    logic [FIELD_YEAR_W-1:0] cur_year;
    logic [1:0]              cur_status;

    logic                    m_valid_reg, m_valid_next;
    logic [DAY_W-1:0]        m_day_reg;
    logic [MONTH_W-1:0]      m_month_reg;
    logic [FIELD_YEAR_W-1:0] m_year_reg;
    logic [1:0]              m_status_reg;

    assign s_ready   = ctrl.accept;
    assign capture   = s_valid && ctrl.accept;
    assign out_busy  = m_valid_reg && !m_ready;
    assign emit_fire = ctrl.emit && !out_busy;

    cda_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .flags    (flags),
        .in_valid (s_valid),
        .out_busy (out_busy),
        .ctrl     (ctrl)
    );

    cda_datapath #(
        .YEAR_BITS  (YEAR_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .capture       (capture),
        .in_operation  (s_operation),
        .in_load_day   (s_load_day),
        .in_load_month (s_load_month),
        .in_load_year  (s_load_year),
        .in_day_count  (s_day_count),
        .dp_op         (ctrl.dp_op),
        .flags         (flags),
        .cur_day       (cur_day),
        .cur_month     (cur_month),
        .cur_year      (cur_year),
        .cur_status    (cur_status)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (emit_fire) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            m_day_reg    <= cur_day;
            m_month_reg  <= cur_month;
            m_year_reg   <= cur_year;
            m_status_reg <= cur_status;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_cur_day   = m_day_reg;
    assign m_cur_month = m_month_reg;
    assign m_cur_year  = m_year_reg;
    assign m_status    = m_status_reg;

endmodule

// ===== rtl/cda_ucode_rom.sv =====
// Read-only microprogram store: one control word per step address.
// Depends on cda_pkg.
module cda_ucode_rom
    import cda_pkg::*;
(
    input  upc_t       addr,
    output ctrl_word_t word
);

    always_comb begin
        case (addr)
            UA_EMIT:       word = mk_word(DP_NOP,        CD_OUT_BUSY, UA_EMIT,      1'b0, 1'b1);
            UA_WAIT:       word = mk_word(DP_NOP,        CD_NO_INPUT, UA_WAIT,      1'b1, 1'b0);
            UA_DISPATCH:   word = mk_word(DP_NOP,        CD_OP_LOAD,  UA_LOAD,      1'b0, 1'b0);
            UA_CHECK:      word = mk_word(DP_ST_BAD,     CD_INVALID,  UA_EMIT,      1'b0, 1'b0);
            UA_QUAD_TEST:  word = mk_word(DP_ST_OK,      CD_NOT_QUAD, UA_FIT_TEST,  1'b0, 1'b0);
            UA_QUAD:       word = mk_word(DP_QUAD,       CD_ALWAYS,   UA_QUAD_TEST, 1'b0, 1'b0);
            UA_FIT_TEST:   word = mk_word(DP_NOP,        CD_FITS,     UA_ADD_DAY,   1'b0, 1'b0);
            UA_YEAR_TEST:  word = mk_word(DP_NOP,        CD_YEAR_END, UA_SATURATE,  1'b0, 1'b0);
            UA_NEXT_MONTH: word = mk_word(DP_NEXT_MONTH, CD_ALWAYS,   UA_FIT_TEST,  1'b0, 1'b0);
            UA_ADD_DAY:    word = mk_word(DP_ADD_DAY,    CD_ALWAYS,   UA_EMIT,      1'b0, 1'b0);
            UA_LOAD:       word = mk_word(DP_LOAD,       CD_ALWAYS,   UA_EMIT,      1'b0, 1'b0);
            UA_SATURATE:   word = mk_word(DP_SATURATE,   CD_ALWAYS,   UA_EMIT,      1'b0, 1'b0);
            default:       word = mk_word(DP_NOP,        CD_ALWAYS,   UA_WAIT,      1'b0, 1'b0);
        endcase
    end

endmodule

// ===== rtl/cda_sequencer.sv =====
// Step counter with conditional jumps over the microprogram store.
// Depends on cda_pkg and cda_ucode_rom.
module cda_sequencer
    import cda_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  dp_flags_t  flags,
    input  logic       in_valid,
    input  logic       out_busy,
    output ctrl_word_t ctrl
);

    upc_t upc_reg;
    upc_t upc_next;
    logic taken;

    cda_ucode_rom u_rom (
        .addr (upc_reg),
        .word (ctrl)
    );

    always_comb begin
        case (ctrl.cond)
            CD_ALWAYS:   taken = 1'b1;
            CD_NO_INPUT: taken = !in_valid;
            CD_OP_LOAD:  taken = flags.op_load;
            CD_INVALID:  taken = flags.invalid;
            CD_NOT_QUAD: taken = flags.not_quad;
            CD_FITS:     taken = flags.fits;
            CD_YEAR_END: taken = flags.year_end;
            CD_OUT_BUSY: taken = out_busy;
            default:     taken = 1'b0;
        endcase
        upc_next = taken ? ctrl.target : upc_reg + upc_t'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= UA_WAIT;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ===== rtl/cda_datapath.sv =====
// Date registers, day counter and the month-step arithmetic driven by the
// control word. Depends on cda_pkg.
module cda_datapath
    import cda_pkg::*;
#(
    parameter int YEAR_BITS  = DEF_YEAR_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     capture,
    input  logic                     in_operation,
    input  logic [DAY_W-1:0]         in_load_day,
    input  logic [MONTH_W-1:0]       in_load_month,
    input  logic [FIELD_YEAR_W-1:0]  in_load_year,
    input  logic [FIELD_COUNT_W-1:0] in_day_count,
    input  dp_op_t                   dp_op,
    output dp_flags_t                flags,
    output logic [DAY_W-1:0]         cur_day,
    output logic [MONTH_W-1:0]       cur_month,
    output logic [FIELD_YEAR_W-1:0]  cur_year,
    output logic [1:0]               cur_status
);

    localparam int LW = COUNT_BITS + FIELD_COUNT_W;
    localparam int YW = YEAR_BITS + FIELD_YEAR_W;
    localparam logic [YEAR_BITS-1:0] YEAR_MAX   = '1;
    localparam logic [YEAR_BITS-1:0] QUAD_LIMIT = YEAR_MAX - YEAR_BITS'(4);

    logic                    op_reg;
    logic [DAY_W-1:0]        ld_day_reg;
    logic [MONTH_W-1:0]      ld_month_reg;
    logic [FIELD_YEAR_W-1:0] ld_year_reg;
    logic [COUNT_BITS-1:0]   left_reg,   left_next;
    logic [DAY_W-1:0]        day_reg,    day_next;
    logic [MONTH_W-1:0]      month_reg,  month_next;
    logic [YEAR_BITS-1:0]    year_reg,   year_next;
    status_t                 status_reg, status_next;

    logic [LW-1:0]           count_wide;
    logic [LW-1:0]           left_wide;
    logic [DAY_W-1:0]        cur_len;
    logic [DAY_W-1:0]        room;
    logic [DAY_W-1:0]        ld_len;
    logic                    ld_month_ok;
    logic                    ld_day_ok;
    logic [YW-1:0]           ld_year_wide;
    logic [YW-1:0]           year_wide;

    assign count_wide   = {COUNT_BITS'(0), in_day_count};
    assign left_wide    = LW'(left_reg);
    assign cur_len      = month_len(month_reg, year_reg[1:0] == 2'd0);
    assign room         = cur_len - day_reg;
    assign ld_month_ok  = (ld_month_reg >= MON_JAN) && (ld_month_reg <= MON_DEC);
    assign ld_len       = month_len(ld_month_reg, ld_year_reg[1:0] == 2'd0);
    assign ld_day_ok    = (ld_day_reg != '0) && (ld_day_reg <= ld_len);
    assign ld_year_wide = {YEAR_BITS'(0), ld_year_reg};
    assign year_wide    = {FIELD_YEAR_W'(0), year_reg};

    assign flags.op_load  = (op_reg == OP_LOAD);
    assign flags.invalid  = (day_reg == '0) || (month_reg == '0);
    assign flags.not_quad = !((left_wide >= LW'(DAYS_FOUR_YEARS)) && (year_reg <= QUAD_LIMIT));
    assign flags.fits     = left_wide <= LW'(room);
    assign flags.year_end = (month_reg == MON_DEC) && (year_reg == YEAR_MAX);

    assign cur_day    = day_reg;
    assign cur_month  = month_reg;
    assign cur_year   = year_wide[FIELD_YEAR_W-1:0];
    assign cur_status = status_reg;

    always_comb begin
        left_next   = left_reg;
        day_next    = day_reg;
        month_next  = month_reg;
        year_next   = year_reg;
        status_next = status_reg;
        if (capture) begin
            left_next = count_wide[COUNT_BITS-1:0];
        end
        case (dp_op)
            DP_ST_BAD: begin
                status_next = ST_INVALID;
            end
            DP_ST_OK: begin
                status_next = ST_OK;
            end
            DP_QUAD: begin
                // four whole years are 1461 days from any valid date
                year_next = year_reg + YEAR_BITS'(4);
                left_next = COUNT_BITS'(left_wide - LW'(DAYS_FOUR_YEARS));
            end
            DP_NEXT_MONTH: begin
                left_next = COUNT_BITS'(left_wide - LW'(room) - LW'(1));
                day_next  = DAY_ONE;
                if (month_reg == MON_DEC) begin
                    month_next = MON_JAN;
                    year_next  = year_reg + YEAR_BITS'(1);
                end else begin
                    month_next = month_reg + MONTH_W'(1);
                end
            end
            DP_ADD_DAY: begin
                day_next = day_reg + left_wide[DAY_W-1:0];
            end
            DP_LOAD: begin
                month_next  = ld_month_ok ? ld_month_reg : '0;
                day_next    = ld_day_ok ? ld_day_reg : '0;
                year_next   = ld_year_wide[YEAR_BITS-1:0];
                status_next = (ld_month_ok && ld_day_ok) ? ST_OK : ST_INVALID;
            end
            DP_SATURATE: begin
                day_next    = DAY_LAST;
                month_next  = MON_DEC;
                year_next   = YEAR_MAX;
                status_next = ST_OVERFLOW;
            end
            default: begin
            end
        endcase
    end

    // Hold the accepted item's fields for the microprogram; register the day counter
    always_ff @(posedge aclk) begin
        if (capture) begin
            op_reg       <= in_operation;
            ld_day_reg   <= in_load_day;
            ld_month_reg <= in_load_month;
            ld_year_reg  <= in_load_year;
        end
        left_reg <= left_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            day_reg    <= '0;
            month_reg  <= '0;
            year_reg   <= '0;
            status_reg <= ST_OK;
        end else begin
            day_reg    <= day_next;
            month_reg  <= month_next;
            year_reg   <= year_next;
            status_reg <= status_next;
        end
    end

endmodule
